// File: rtl/core/rfp_pkg.sv
// Shared types and constants of the response frame parser.
`timescale 1ns / 1ps

package rfp_pkg;

   localparam int ByteW    = 8;
   localparam int CsrAddrW = 4;
   localparam int CsrDataW = 32;

   // register indexes, taken from paddr[3:2]
   localparam logic [1:0] RegStart = 2'd0;
   localparam logic [1:0] RegEnd   = 2'd1;
   localparam logic [1:0] RegAck   = 2'd2;
   localparam logic [1:0] RegNak   = 2'd3;

   localparam logic [ByteW-1:0] StartReset = 8'd2;
   localparam logic [ByteW-1:0] EndReset   = 8'd3;
   localparam logic [ByteW-1:0] AckReset   = 8'd6;
   localparam logic [ByteW-1:0] NakReset   = 8'd21;

   localparam logic [ByteW-1:0] LengthOverhead = 8'd2;

   typedef struct packed {
      logic [ByteW-1:0] start_marker;
      logic [ByteW-1:0] end_marker;
      logic [ByteW-1:0] ack_marker;
      logic [ByteW-1:0] nak_marker;
   } markers_type;

   typedef struct packed {
      logic             frame_done;
      logic             payload_valid;
      logic [ByteW-1:0] payload_byte;
      logic [ByteW-1:0] payload_index;
      logic [ByteW-1:0] frame_length;
      logic [ByteW-1:0] message_id;
      logic             was_refused;
      logic [ByteW-1:0] error_code;
      logic [ByteW-1:0] checksum_byte;
   } result_type;

endpackage

// File: rtl/core/rfp_channels.sv
// Valid/ready channel interfaces for received bytes and parse results.
`timescale 1ns / 1ps

interface rfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface rfp_rsp_if;
   logic       valid;
   logic       ready;
   logic       frame_done;
   logic       payload_valid;
   logic [7:0] payload_byte;
   logic [7:0] payload_index;
   logic [7:0] frame_length;
   logic [7:0] message_id;
   logic       was_refused;
   logic [7:0] error_code;
   logic [7:0] checksum_byte;

   modport source (output valid, output frame_done, output payload_valid,
                   output payload_byte, output payload_index, output frame_length,
                   output message_id, output was_refused, output error_code,
                   output checksum_byte, input ready);
   modport sink (input valid, input frame_done, input payload_valid,
                 input payload_byte, input payload_index, input frame_length,
                 input message_id, input was_refused, input error_code,
                 input checksum_byte, output ready);
endinterface

// File: rtl/core/rfp_csr.sv
// APB-style register file holding the four framing marker bytes.
`timescale 1ns / 1ps

module rfp_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [rfp_pkg::CsrAddrW-1:0]   paddr,
   input  logic [rfp_pkg::CsrDataW-1:0]   pwdata,
   output logic [rfp_pkg::CsrDataW-1:0]   prdata,
   output logic                           pready,
   output rfp_pkg::markers_type           markers
);
   import rfp_pkg::*;

   markers_type      markers_ff;
   markers_type      markers_in;
   logic [1:0]       reg_index;
   logic             wr_en;
   logic [ByteW-1:0] wr_byte;
   logic [ByteW-1:0] rd_byte;

   assign reg_index = paddr[3:2];
   assign wr_en     = psel & penable & pwrite;
   assign wr_byte   = pwdata[ByteW-1:0];
   assign pready    = 1'b1;

   always_comb begin
      markers_in = markers_ff;
      if (wr_en) begin
         case (reg_index)
            RegStart: markers_in.start_marker = wr_byte;
            RegEnd:   markers_in.end_marker   = wr_byte;
            RegAck:   markers_in.ack_marker   = wr_byte;
            RegNak:   markers_in.nak_marker   = wr_byte;
            default:  markers_in = markers_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         markers_ff.start_marker <= StartReset;
         markers_ff.end_marker   <= EndReset;
         markers_ff.ack_marker   <= AckReset;
         markers_ff.nak_marker   <= NakReset;
      end else begin
         markers_ff <= markers_in;
      end
   end

   always_comb begin
      case (reg_index)
         RegStart: rd_byte = markers_ff.start_marker;
         RegEnd:   rd_byte = markers_ff.end_marker;
         RegAck:   rd_byte = markers_ff.ack_marker;
         RegNak:   rd_byte = markers_ff.nak_marker;
         default:  rd_byte = '0;
      endcase
   end

   assign prdata  = {{(CsrDataW-ByteW){1'b0}}, rd_byte};
   assign markers = markers_ff;

endmodule

// File: rtl/core/rfp_parser.sv
// Per-byte frame state machine: captures header fields and forms one result per byte.
`timescale 1ns / 1ps

module rfp_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  rfp_pkg::markers_type         markers,
   input  logic                         take,
   input  logic [rfp_pkg::ByteW-1:0]    rx_byte,
   output rfp_pkg::result_type          result
);
   import rfp_pkg::*;

   localparam logic [2:0] PhHunt   = 3'd0;
   localparam logic [2:0] PhLength = 3'd1;
   localparam logic [2:0] PhId     = 3'd2;
   localparam logic [2:0] PhResp   = 3'd3;
   localparam logic [2:0] PhData   = 3'd4;
   localparam logic [2:0] PhErr    = 3'd5;
   localparam logic [2:0] PhCheck  = 3'd6;
   localparam logic [2:0] PhEnd    = 3'd7;

   logic [2:0]       phase_ff,   phase_in;
   logic [ByteW-1:0] count_ff,   count_in;
   logic [ByteW-1:0] length_ff,  length_in;
   logic [ByteW-1:0] id_ff,      id_in;
   logic             refused_ff, refused_in;
   logic [ByteW-1:0] error_ff,   error_in;
   logic [ByteW-1:0] check_ff,   check_in;
   logic [ByteW-1:0] count_inc;
   logic             done;
   logic             pvalid;

   assign count_inc = count_ff + 8'd1;

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      length_in  = length_ff;
      id_in      = id_ff;
      refused_in = refused_ff;
      error_in   = error_ff;
      check_in   = check_ff;
      done       = 1'b0;
      pvalid     = 1'b0;
      case (phase_ff)
         PhHunt: begin
            if (rx_byte == markers.start_marker) phase_in = PhLength;
         end
         PhLength: begin
            length_in = rx_byte;
            phase_in  = PhId;
         end
         PhId: begin
            id_in    = rx_byte;
            phase_in = PhResp;
         end
         PhResp: begin
            // ACK wins when both markers hold the same value; anything else waits
            if (rx_byte == markers.ack_marker) begin
               refused_in = 1'b0;
               if (length_ff > LengthOverhead) begin
                  count_in = '0;
                  phase_in = PhData;
               end else begin
                  phase_in = PhCheck;
               end
            end else if (rx_byte == markers.nak_marker) begin
               refused_in = 1'b1;
               phase_in   = PhErr;
            end
         end
         PhData: begin
            pvalid   = 1'b1;
            count_in = count_inc;
            if (count_inc >= length_ff - LengthOverhead) phase_in = PhCheck;
         end
         PhErr: begin
            error_in = rx_byte;
            phase_in = PhCheck;
         end
         PhCheck: begin
            check_in = rx_byte;
            phase_in = PhEnd;
         end
         default: begin
            // a wrong end byte drops back to the hunt without a frame
            done     = (rx_byte == markers.end_marker);
            phase_in = PhHunt;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PhHunt;
         count_ff   <= '0;
         length_ff  <= '0;
         id_ff      <= '0;
         refused_ff <= 1'b0;
         error_ff   <= '0;
         check_ff   <= '0;
      end else if (take) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         length_ff  <= length_in;
         id_ff      <= id_in;
         refused_ff <= refused_in;
         error_ff   <= error_in;
         check_ff   <= check_in;
      end
   end

   always_comb begin
      result.frame_done    = done;
      result.payload_valid = pvalid;
      result.payload_byte  = pvalid ? rx_byte : '0;
      result.payload_index = pvalid ? count_ff : '0;
      result.frame_length  = length_in;
      result.message_id    = id_in;
      result.was_refused   = refused_in;
      result.error_code    = refused_in ? error_in : '0;
      result.checksum_byte = check_in;
   end

endmodule

// File: rtl/core/rfp_out_stage.sv
// Result register that decouples the byte input from a stalled result consumer.
`timescale 1ns / 1ps

module rfp_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  rfp_pkg::result_type  in_result,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rfp_pkg::result_type  out_result
);
   import rfp_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;
   logic       load;

   // accept while empty or while the held result leaves this cycle
   assign in_ready = ~valid_ff | out_ready;
   assign load     = in_valid & in_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) valid_in = 1'b1;
      else if (out_ready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load) result_ff <= in_result;
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

// File: rtl/core/response_frame_parser.sv
// Top level of the response frame parser: registers, parser and result register.
`timescale 1ns / 1ps

// Byte-at-a-time deframer for start/length/id/response/.../checksum/end frames.
// Every received byte transfer produces exactly one registered result transfer
// once it is accepted; a new byte is accepted every cycle while the result
// register is empty or being drained, so throughput is one byte per clock.
// The single result register is what limits buffering: a stalled consumer
// stalls the byte input after one held result. ACK frames emit payload bytes
// as they arrive with their index; NAK frames capture an error code. The
// checksum is captured but not checked. Marker registers sit at byte addresses
// 0 (start), 4 (end), 8 (ack), 12 (nak) and should be written only while idle.

module response_frame_parser (
   input  logic                          clock,
   input  logic                          reset,
   rfp_req_if.sink                       req,
   rfp_rsp_if.source                     rsp,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rfp_pkg::CsrAddrW-1:0]  paddr,
   input  logic [rfp_pkg::CsrDataW-1:0]  pwdata,
   output logic [rfp_pkg::CsrDataW-1:0]  prdata,
   output logic                          pready
);
   import rfp_pkg::*;

   markers_type markers;
   result_type  step_result;
   result_type  held_result;
   logic        take;

   rfp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .markers (markers)
   );

   assign take = req.valid & req.ready;

   rfp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .markers (markers),
      .take    (take),
      .rx_byte (req.rx_byte),
      .result  (step_result)
   );

   rfp_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req.valid),
      .in_ready   (req.ready),
      .in_result  (step_result),
      .out_valid  (rsp.valid),
      .out_ready  (rsp.ready),
      .out_result (held_result)
   );

   assign rsp.frame_done    = held_result.frame_done;
   assign rsp.payload_valid = held_result.payload_valid;
   assign rsp.payload_byte  = held_result.payload_byte;
   assign rsp.payload_index = held_result.payload_index;
   assign rsp.frame_length  = held_result.frame_length;
   assign rsp.message_id    = held_result.message_id;
   assign rsp.was_refused   = held_result.was_refused;
   assign rsp.error_code    = held_result.error_code;
   assign rsp.checksum_byte = held_result.checksum_byte;

endmodule

// File: tb/response_frame_parser_tb.sv
// Self-checking testbench of the response frame parser: directed frames, then random frames.
`timescale 1ns / 1ps

module response_frame_parser_tb;
   import rfp_pkg::*;

   localparam int unsigned CycleLimit = 200000;
   localparam int unsigned PhaseBytes = 20;

   typedef enum logic [2:0] {
      PhHunt, PhLength, PhId, PhResp, PhData, PhErr, PhCheck, PhEnd
   } parse_phase_type;

   // Tracks the parser state, predicts one result per received byte and
   // checks the results in order.
   class frame_tracker_type;
      markers_type       markers;
      parse_phase_type   phase;
      logic [ByteW-1:0]  data_seen;
      logic [ByteW-1:0]  len_q;
      logic [ByteW-1:0]  id_q;
      logic              refused_q;
      logic [ByteW-1:0]  err_q;
      logic [ByteW-1:0]  check_q;
      result_type        pending_results[$];
      int                mismatches;

      function new();
         markers = '{StartReset, EndReset, AckReset, NakReset};
         phase = PhHunt;
         data_seen = '0;
         len_q = '0;
         id_q = '0;
         refused_q = 1'b0;
         err_q = '0;
         check_q = '0;
         mismatches = 0;
      endfunction

      function void set_marker(logic [1:0] idx, logic [ByteW-1:0] value);
         case (idx)
            RegStart: markers.start_marker = value;
            RegEnd:   markers.end_marker = value;
            RegAck:   markers.ack_marker = value;
            default:  markers.nak_marker = value;
         endcase
      endfunction

      function void check_marker(logic [1:0] idx, logic [ByteW-1:0] got);
         logic [ByteW-1:0] want;
         case (idx)
            RegStart: want = markers.start_marker;
            RegEnd:   want = markers.end_marker;
            RegAck:   want = markers.ack_marker;
            default:  want = markers.nak_marker;
         endcase
         compare_field($sformatf("marker %0d readback", idx), want, got);
      endfunction

      // Advance the parser by one accepted byte and queue its result.
      function void parse_byte(logic [ByteW-1:0] b);
         result_type r;
         r = '0;
         case (phase)
            PhHunt: if (b == markers.start_marker) phase = PhLength;
            PhLength: begin
               len_q = b;
               phase = PhId;
            end
            PhId: begin
               id_q = b;
               phase = PhResp;
            end
            PhResp: begin
               // ACK wins when both markers are equal; anything else is skipped
               if (b == markers.ack_marker) begin
                  refused_q = 1'b0;
                  if (len_q > LengthOverhead) begin
                     data_seen = '0;
                     phase = PhData;
                  end else begin
                     phase = PhCheck;
                  end
               end else if (b == markers.nak_marker) begin
                  refused_q = 1'b1;
                  phase = PhErr;
               end
            end
            PhData: begin
               r.payload_valid = 1'b1;
               r.payload_byte = b;
               r.payload_index = data_seen;
               data_seen = data_seen + 1'b1;
               if (int'(data_seen) >= int'(len_q) - int'(LengthOverhead)) phase = PhCheck;
            end
            PhErr: begin
               err_q = b;
               phase = PhCheck;
            end
            PhCheck: begin
               check_q = b;
               phase = PhEnd;
            end
            default: begin
               r.frame_done = (b == markers.end_marker);
               phase = PhHunt;
            end
         endcase
         r.frame_length = len_q;
         r.message_id = id_q;
         r.was_refused = refused_q;
         r.error_code = refused_q ? err_q : '0;
         r.checksum_byte = check_q;
         pending_results.push_back(r);
      endfunction

      function void compare_field(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         end
      endfunction

      function void check_parse_result(result_type got);
         result_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result transfer, actual %p", $time, got);
            return;
         end
         want = pending_results.pop_front();
         compare_field("frame_done", want.frame_done, got.frame_done);
         compare_field("payload_valid", want.payload_valid, got.payload_valid);
         compare_field("payload_byte", want.payload_byte, got.payload_byte);
         compare_field("payload_index", want.payload_index, got.payload_index);
         compare_field("frame_length", want.frame_length, got.frame_length);
         compare_field("message_id", want.message_id, got.message_id);
         compare_field("was_refused", want.was_refused, got.was_refused);
         compare_field("error_code", want.error_code, got.error_code);
         compare_field("checksum_byte", want.checksum_byte, got.checksum_byte);
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [CsrAddrW-1:0] paddr;
   logic [CsrDataW-1:0] pwdata;
   logic [CsrDataW-1:0] prdata;
   logic                pready;

   rfp_req_if req_ch ();
   rfp_rsp_if rsp_ch ();

   frame_tracker_type tracker = new();
   int unsigned  bytes_sent = 0;
   int unsigned  cycle_count = 0;
   bit           req_steady = 1'b0;
   bit           rsp_steady = 1'b0;
   int           rsp_stall = 0;

   response_frame_parser DUT (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [ByteW-1:0] rnd_byte();
      return ByteW'($urandom_range(0, 255));
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall = 0;
      end else if (rsp_stall > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_ch.ready <= 1'b1;
         if ($urandom_range(0, 199) == 0) rsp_steady = !rsp_steady;
         if (!rsp_steady && $urandom_range(0, 3) == 0) rsp_stall = pick_gap();
      end
   end

   always @(posedge clock) begin : watch
      result_type seen;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) tracker.parse_byte(req_ch.rx_byte);
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.frame_done = rsp_ch.frame_done;
            seen.payload_valid = rsp_ch.payload_valid;
            seen.payload_byte = rsp_ch.payload_byte;
            seen.payload_index = rsp_ch.payload_index;
            seen.frame_length = rsp_ch.frame_length;
            seen.message_id = rsp_ch.message_id;
            seen.was_refused = rsp_ch.was_refused;
            seen.error_code = rsp_ch.error_code;
            seen.checksum_byte = rsp_ch.checksum_byte;
            tracker.check_parse_result(seen);
         end
      end
   end

   task automatic send_byte(input logic [ByteW-1:0] value);
      req_ch.valid <= 1'b1;
      req_ch.rx_byte <= value;
      do @(posedge clock); while (!req_ch.ready);
      bytes_sent++;
      if ($urandom_range(0, 149) == 0) req_steady = !req_steady;
      if (!req_steady && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
   endtask

   // Drop valid and wait for every outstanding result.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write a marker register, then read it back.
   task automatic write_marker(input logic [1:0] idx, input logic [ByteW-1:0] value);
      logic [CsrDataW-1:0] word;
      word = $urandom;
      word[ByteW-1:0] = value;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      tracker.set_marker(idx, value);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      tracker.check_marker(idx, prdata[ByteW-1:0]);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_markers(input logic [ByteW-1:0] start_v, input logic [ByteW-1:0] end_v,
                                input logic [ByteW-1:0] ack_v, input logic [ByteW-1:0] nak_v);
      settle();
      write_marker(RegStart, start_v);
      write_marker(RegEnd, end_v);
      write_marker(RegAck, ack_v);
      write_marker(RegNak, nak_v);
   endtask

   // One frame with random content, at times with an unknown response or bad end byte, or a burst of noise.
   task automatic send_frame(input bit long_one);
      int               len;
      int               body;
      logic [ByteW-1:0] b;
      if (!long_one && $urandom_range(0, 99) < 20) begin
         repeat ($urandom_range(1, 6)) begin
            b = ($urandom_range(0, 4) == 0) ? tracker.markers.start_marker : rnd_byte();
            send_byte(b);
         end
      end else begin
         if (long_one) len = 255;
         else if ($urandom_range(0, 9) == 0) len = $urandom_range(0, 40);
         else len = $urandom_range(0, 10);
         send_byte(tracker.markers.start_marker);
         send_byte(len[ByteW-1:0]);
         send_byte(rnd_byte());
         if ($urandom_range(0, 9) == 0) begin
            do b = rnd_byte();
            while (b == tracker.markers.ack_marker || b == tracker.markers.nak_marker);
            send_byte(b);
         end
         if (long_one || $urandom_range(0, 9) < 6) begin
            send_byte(tracker.markers.ack_marker);
            body = (len > 2) ? len - 2 : 0;
            repeat (body) send_byte(rnd_byte());
         end else begin
            send_byte(tracker.markers.nak_marker);
            send_byte(rnd_byte());
         end
         send_byte(rnd_byte());
         if ($urandom_range(0, 6) == 0) begin
            do b = rnd_byte();
            while (b == tracker.markers.end_marker);
            send_byte(b);
         end else begin
            send_byte(tracker.markers.end_marker);
         end
      end
   endtask

   task automatic run_frames(input int unsigned count);
      int unsigned first;
      first = bytes_sent;
      while (bytes_sent - first < count) send_frame(1'b0);
   endtask

   initial begin : stimulus
      logic [ByteW-1:0] warmup[$];
      logic [ByteW-1:0] shared;
      warmup = '{8'hFF,
                 StartReset, 8'd5, 8'hA5, AckReset, 8'h00, 8'hFF, 8'h5A, 8'h81, EndReset,
                 StartReset, 8'd2, 8'h7E, 8'h33, NakReset, 8'hFF, 8'h00, 8'h55,
                 StartReset, 8'd1, 8'h00, AckReset, 8'hC3, EndReset};
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_ch.valid = 1'b0;
      req_ch.rx_byte = '0;
      rsp_ch.ready = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset markers: noise, ACK with payload, NAK after an unknown response
      // with a bad end byte, short ACK without payload
      foreach (warmup[i]) send_byte(warmup[i]);

      write_markers(rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());
      run_frames(PhaseBytes);

      write_markers(8'h00, 8'hFF, 8'h00, 8'hFF);
      send_frame(1'b1);
      run_frames(PhaseBytes);

      write_markers(8'hFF, 8'h00, 8'hFF, 8'h00);
      run_frames(PhaseBytes);

      // identical ACK and NAK markers
      shared = rnd_byte();
      write_markers(rnd_byte(), rnd_byte(), shared, shared);
      run_frames(PhaseBytes);

      write_markers(rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());
      run_frames(PhaseBytes);

      write_markers(StartReset, EndReset, AckReset, NakReset);
      run_frames(PhaseBytes);

      settle();
      repeat (10) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
